### hw/rtl/jbp_pkg.sv
package jbp_pkg;

    // Default longest code, in bits
    localparam int MAX_CODE_BITS_DEF = 16;

    // Width of the code value field
    localparam int CODE_W = 16;

    // Width of the code length field
    localparam int LEN_W = 5;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // Byte that forces a stuffed zero after it
    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

    // Zero byte inserted after an all-ones byte
    localparam logic [7:0] STUFF_BYTE = 8'h00;

    // Bit position of the most significant free bit
    localparam logic [2:0] TOP_BIT_POS = 3'd7;

endpackage

### hw/rtl/jbp_front.sv
module jbp_front
    import jbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    localparam int NB = (7 + MAX_CODE_BITS) / 8,
    localparam int NBW = $clog2(NB + 1),
    localparam int ENT_W = NB * 8 + NBW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_len,
    input  logic              flush,
    output logic              push,
    output logic [ENT_W-1:0]  push_data
);

    localparam int WW = 8 * (NB + 1);
    localparam int SW = $clog2(WW + 1);
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int TW = $clog2(7 + MAX_CODE_BITS + 1);

    logic [7:0]          pend_reg;
    logic [7:0]          pend_next;
    logic [2:0]          free_reg;
    logic [2:0]          free_next;

    logic [2:0]          nfill;
    logic [LW-1:0]       len_sat;
    logic [CODE_W-1:0]   code_m;
    logic [SW-1:0]       sh;
    logic [WW-1:0]       win;
    logic [TW-1:0]       total;
    logic [NBW-1:0]      nb_code;
    logic [7:0]          pend_code;
    logic [7:0]          pad;
    logic [7:0]          flush_byte;
    logic [NB*8-1:0]     bytes_code;

    // Place the code below the bits already pending, left aligned
    always_comb
    begin
        nfill = TOP_BIT_POS - free_reg;
        if (6'(code_len) > 6'(MAX_CODE_BITS))
        begin
            len_sat = LW'(MAX_CODE_BITS);
        end
        else
        begin
            len_sat = LW'(code_len);
        end
        if (6'(len_sat) >= 6'(CODE_W))
        begin
            code_m = code_bits;
        end
        else
        begin
            code_m = code_bits & ((CODE_W'(1) << len_sat) - CODE_W'(1));
        end
        sh = SW'(WW) - SW'(nfill) - SW'(len_sat);
        win = {pend_reg, (WW-8)'(0)} | (WW'(code_m) << sh);
        total = TW'(nfill) + TW'(len_sat);
        nb_code = NBW'(total >> 3);
        for (int k = 0; k < NB; k++)
        begin
            bytes_code[8*k +: 8] = win[WW-1-8*k -: 8];
        end
        pend_code = 8'h00;
        for (int k = 0; k <= NB; k++)
        begin
            if (NBW'(k) == nb_code)
            begin
                pend_code = win[WW-1-8*k -: 8];
            end
        end
    end

    // Pad the free low bits with ones on flush
    assign pad        = ~(8'hFF << (4'(free_reg) + 4'd1));
    assign flush_byte = pend_reg | pad;

    // Select the work for the back end and the next state
    always_comb
    begin
        if (flush)
        begin
            push      = accept && (free_reg != TOP_BIT_POS);
            push_data = {NBW'(1), (NB*8)'(flush_byte)};
            pend_next = 8'h00;
            free_next = TOP_BIT_POS;
        end
        else
        begin
            push      = accept && (nb_code != '0);
            push_data = {nb_code, bytes_code};
            pend_next = pend_code;
            free_next = TOP_BIT_POS - total[2:0];
        end
    end

    // Hold the partial byte between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 8'h00;
            free_reg <= TOP_BIT_POS;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            free_reg <= free_next;
        end
    end

endmodule

### hw/rtl/jbp_queue.sv
module jbp_queue
    import jbp_pkg::*;
#(
    parameter int ENT_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [ENT_W-1:0] push_data,
    output logic             full,
    output logic             head_valid,
    output logic [ENT_W-1:0] head_data,
    input  logic             pop
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [ENT_W-1:0] ent_reg [Q_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;

    assign full       = (cnt_reg == CW'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = ent_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/jbp_back.sv
module jbp_back
    import jbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    localparam int NB = (7 + MAX_CODE_BITS) / 8,
    localparam int NBW = $clog2(NB + 1),
    localparam int ENT_W = NB * 8 + NBW
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  logic [ENT_W-1:0] head_data,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    localparam int IW = (NB > 1) ? $clog2(NB) : 1;

    logic [IW-1:0]  idx_reg;
    logic [IW-1:0]  idx_next;
    logic           stuff_reg;
    logic           stuff_next;
    logic           vld_reg;
    logic           vld_next;
    logic [7:0]     data_reg;
    logic [7:0]     data_next;
    logic           last_reg;
    logic           last_next;

    logic [NBW-1:0] head_nb;
    logic [7:0]     cur_byte;
    logic           is_final;
    logic           load;

    assign head_nb  = head_data[ENT_W-1 -: NBW];
    assign is_final = ((NBW'(idx_reg) + NBW'(1)) == head_nb);
    assign load     = !vld_reg || m_tready;

    // Pick the current byte of the entry
    always_comb
    begin
        cur_byte = 8'h00;
        for (int k = 0; k < NB; k++)
        begin
            if (IW'(k) == idx_reg)
            begin
                cur_byte = head_data[8*k +: 8];
            end
        end
    end

    // Step through the entry one byte a cycle while the output register can load, inserting the stuffed zero
    always_comb
    begin
        idx_next   = idx_reg;
        stuff_next = stuff_reg;
        vld_next   = vld_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            vld_next = head_valid;
            if (head_valid)
            begin
                if (stuff_reg)
                begin
                    data_next  = STUFF_BYTE;
                    last_next  = is_final;
                    stuff_next = 1'b0;
                    pop        = is_final;
                    idx_next   = is_final ? '0 : idx_reg + IW'(1);
                end
                else if (cur_byte == BYTE_ALL_ONES)
                begin
                    data_next  = cur_byte;
                    last_next  = 1'b0;
                    stuff_next = 1'b1;
                end
                else
                begin
                    data_next = cur_byte;
                    last_next = is_final;
                    pop       = is_final;
                    idx_next  = is_final ? '0 : idx_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            stuff_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            stuff_reg <= stuff_next;
            vld_reg   <= vld_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/jpeg_bit_packer_byte_stuffing_core.sv
// Channel | Dir | Signals                      | Contents
// s       | in  | s_tvalid s_tready s_tdata    | code word: code_bits, code_len
//         |     | s_tuser                      | flush
// m       | out | m_tvalid m_tready m_tdata    | out_byte
//         |     | m_tlast                      | last_of_run
//
// The front takes one word a cycle while the queue has room and folds it into
// the pending byte in that same cycle; zero-length codes and empty flushes
// leave nothing for the back.
// The back sends one byte a cycle from its output register while m is ready, and
// a word produces up to 2*NB bytes, stuffed zeros included.
// Reset clears the pending byte, the queue and the output valid flag, not the output data.
// A stall on m fills the two-entry queue, after which s_tready drops.
module jpeg_bit_packer_byte_stuffing_core
    import jbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] code_bits, [20:16] code_len, [23:21] zero
    input  logic        s_tuser,   // [0] flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    localparam int NB = (7 + MAX_CODE_BITS) / 8;
    localparam int NBW = $clog2(NB + 1);
    localparam int ENT_W = NB * 8 + NBW;

    logic             accept;
    logic             push;
    logic [ENT_W-1:0] push_data;
    logic             q_full;
    logic             head_valid;
    logic [ENT_W-1:0] head_data;
    logic             pop;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    jbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_bits (s_tdata[CODE_W-1:0]),
        .code_len  (s_tdata[CODE_W +: LEN_W]),
        .flush     (s_tuser),
        .push      (push),
        .push_data (push_data)
    );

    jbp_queue #(
        .ENT_W (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    jbp_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### hw/rtl/jbp_checker.sv
module jbp_checker
    import jbp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // An all-ones byte never ends a run
    a_ff_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == BYTE_ALL_ONES) |-> !m_tlast)
        else $error("all-ones byte marked last");

    // Follow a taken all-ones byte with the stuffed zero at once
    a_stuff_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tdata == BYTE_ALL_ONES)
        |=> m_tvalid && (m_tdata == STUFF_BYTE))
        else $error("stuffed zero missing after all-ones byte");

    // Come out of reset with nothing to send
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind jpeg_bit_packer_byte_stuffing_core jbp_checker u_jbp_checker (.*);
